### rtl/two_level_writeback_cache_core_assert.svh
// assertion macros used by the checker file of the cache core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TWO_LEVEL_WRITEBACK_CACHE_CORE_ASSERT_SVH
`define TWO_LEVEL_WRITEBACK_CACHE_CORE_ASSERT_SVH

// same-cycle implication
`define TLWC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlwc check failed");

// next-cycle implication
`define TLWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlwc check failed");

`endif

### rtl/tlwc_pkg.sv
// package of the two-level write-back cache core
// holds action codes, register indexes, move kinds and fixed geometry
package tlwc_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } act_e;

  localparam int unsigned CFG_NUM   = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COST_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_L1_RD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_RD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_RD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR = 3'd5;

  localparam logic [COST_W-1:0] CFG_RESET [CFG_NUM] = '{
    16'd1, 16'd1, 16'd10, 16'd10, 16'd100, 16'd50
  };

  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned LINE_BYTES = 64;
  localparam int unsigned WPL        = LINE_BYTES / WORD_BYTES;
  localparam int unsigned WOFF_W     = 4;
  localparam int unsigned LINE_LSB   = 6;
  localparam int unsigned L1_LINES   = 256;
  localparam int unsigned L2_LINES   = 512;
  localparam int unsigned L1_IDX_W   = 8;
  localparam int unsigned L2_IDX_W   = 9;
  localparam int unsigned L1_TAG_LSB = 14;
  localparam int unsigned L2_TAG_LSB = 15;

  typedef enum logic [1:0] {
    MV_L1_TO_L2  = 2'd0,
    MV_L2_TO_L1  = 2'd1,
    MV_L2_TO_MEM = 2'd2,
    MV_MEM_TO_L2 = 2'd3
  } move_e;

endpackage

### rtl/tlwc_if.sv
// handshake channels of the cache core: request, response and register write
// depends on tlwc_pkg
interface tlwc_req_if;
  logic             valid;
  logic             ready;
  tlwc_pkg::act_e   action;
  logic [31:0]      address;
  logic [31:0]      write_data;
  modport source (output valid, action, address, write_data, input ready);
  modport sink (input valid, action, address, write_data, output ready);
endinterface

interface tlwc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] elapsed_cost;
  logic        l1_hit;
  logic        l2_hit;
  logic        range_error;
  modport source (output valid, read_data, elapsed_cost, l1_hit, l2_hit, range_error,
                  input ready);
  modport sink (input valid, read_data, elapsed_cost, l1_hit, l2_hit, range_error,
                output ready);
endinterface

interface tlwc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlwc_pkg::CFG_IDX_W-1:0] index;
  logic [tlwc_pkg::COST_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/tlwc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module tlwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/two_level_writeback_cache_core.sv
// Two-level direct-mapped write-back cache (256-line L1, 512-line L2, 64-byte lines) in
// front of a zeroed backing memory, with a running 32-bit access cost counter. After reset
// the core sweeps the backing memory and the tag stores before the first item is taken. An
// L1 hit reads tag and word, then compares and accesses the word. An L1 miss adds an L2
// line operation, each with its L2 tag lookup, per dirty L1 victim and then for the fill,
// plus a backing memory line move per dirty L2 victim and fill; all line moves go word
// by word through the data rams. Clears, no-ops and out-of-range accesses go straight to
// the response state. Depends on tlwc_pkg, tlwc_if and tlwc_ram.
module two_level_writeback_cache_core #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlwc_req_if.sink   req_i,
  tlwc_rsp_if.source rsp_o,
  tlwc_cfg_if.sink   cfg_i
);

  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned MEM_WORDS = MEM_BYTES / tlwc_pkg::WORD_BYTES;
  localparam int unsigned MEM_WAW   = MEM_AW - 2;
  localparam int unsigned LA_W      = MEM_AW - tlwc_pkg::LINE_LSB;
  localparam int unsigned L1_TAG_W  = MEM_AW - tlwc_pkg::L1_TAG_LSB;
  localparam int unsigned L2_TAG_W  = (MEM_AW > tlwc_pkg::L2_TAG_LSB) ?
                                      MEM_AW - tlwc_pkg::L2_TAG_LSB : 1;
  localparam int unsigned L1M_W     = L1_TAG_W + 2;
  localparam int unsigned L2M_W     = L2_TAG_W + 2;
  localparam int unsigned L1D_AW    = tlwc_pkg::L1_IDX_W + tlwc_pkg::WOFF_W;
  localparam int unsigned L2D_AW    = tlwc_pkg::L2_IDX_W + tlwc_pkg::WOFF_W;
  localparam int unsigned K_W       = tlwc_pkg::WOFF_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_L1    = 3'd2;
  localparam logic [2:0] ST_L2M   = 3'd3;
  localparam logic [2:0] ST_L2C   = 3'd4;
  localparam logic [2:0] ST_MOVE  = 3'd5;
  localparam logic [2:0] ST_L1UP  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [MEM_WAW-1:0]         clr_q, clr_d;
  logic [tlwc_pkg::COST_W-1:0] cfg_q [tlwc_pkg::CFG_NUM];
  logic [31:0]                cnt_q, cnt_d;
  tlwc_pkg::act_e             act_q, act_d;
  logic [tlwc_pkg::L1_IDX_W-1:0] idx1_q, idx1_d;
  logic [L1_TAG_W-1:0]        tag1_q, tag1_d;
  logic [tlwc_pkg::WOFF_W-1:0] word_q, word_d;
  logic [31:0]                wdata_q, wdata_d;
  logic                       miss_q, miss_d;
  logic                       h1_q, h1_d;
  logic                       h2_q, h2_d;
  logic                       err_q, err_d;
  logic [31:0]                rd_q, rd_d;
  logic                       phase_q, phase_d;
  logic [LA_W-1:0]            la_q, la_d;
  logic                       l2wr_q, l2wr_d;
  logic                       l2hit_q, l2hit_d;
  logic                       l2dirty_q, l2dirty_d;
  tlwc_pkg::move_e            mv_q, mv_d;
  logic [K_W-1:0]             k_q, k_d;
  logic [LA_W-1:0]            mla_q, mla_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rd_q, out_rd_d;
  logic [31:0] out_cost_q, out_cost_d;
  logic        out_h1_q, out_h1_d;
  logic        out_h2_q, out_h2_d;
  logic        out_err_q, out_err_d;

  logic                l1d_we;
  logic [L1D_AW-1:0]   l1d_waddr, l1d_raddr;
  logic [31:0]         l1d_wdata, l1d_rdata;
  logic                l1m_we;
  logic [tlwc_pkg::L1_IDX_W-1:0] l1m_waddr, l1m_raddr;
  logic [L1M_W-1:0]    l1m_wdata, l1m_rdata;
  logic                l2d_we;
  logic [L2D_AW-1:0]   l2d_waddr, l2d_raddr;
  logic [31:0]         l2d_wdata, l2d_rdata;
  logic                l2m_we;
  logic [tlwc_pkg::L2_IDX_W-1:0] l2m_waddr, l2m_raddr;
  logic [L2M_W-1:0]    l2m_wdata, l2m_rdata;
  logic                mem_we;
  logic [MEM_WAW-1:0]  mem_waddr, mem_raddr;
  logic [31:0]         mem_wdata, mem_rdata;

  logic                         out_free;
  logic [tlwc_pkg::L2_IDX_W-1:0] idx2;
  logic [LA_W:0]                la_ext;
  logic [L2_TAG_W-1:0]          tag2;
  logic [tlwc_pkg::WOFF_W-1:0]  k4, km1;
  logic                         l1_hit_now;
  logic                         l2_hit_now;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign idx2     = la_q[tlwc_pkg::L2_IDX_W-1:0];
  assign la_ext   = {1'b0, la_q};
  assign tag2     = la_ext[tlwc_pkg::L2_IDX_W +: L2_TAG_W];
  assign k4       = k_q[tlwc_pkg::WOFF_W-1:0];
  assign km1      = k4 - 1'b1;
  assign l1_hit_now = miss_q ||
                      (l1m_rdata[L1M_W-1] && (l1m_rdata[L1_TAG_W-1:0] == tag1_q));
  assign l2_hit_now = l2m_rdata[L2M_W-1] && (l2m_rdata[L2_TAG_W-1:0] == tag2);

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_data    = out_rd_q;
  assign rsp_o.elapsed_cost = out_cost_q;
  assign rsp_o.l1_hit       = out_h1_q;
  assign rsp_o.l2_hit       = out_h2_q;
  assign rsp_o.range_error  = out_err_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    act_d     = act_q;
    idx1_d    = idx1_q;
    tag1_d    = tag1_q;
    word_d    = word_q;
    wdata_d   = wdata_q;
    miss_d    = miss_q;
    h1_d      = h1_q;
    h2_d      = h2_q;
    err_d     = err_q;
    rd_d      = rd_q;
    phase_d   = phase_q;
    la_d      = la_q;
    l2wr_d    = l2wr_q;
    l2hit_d   = l2hit_q;
    l2dirty_d = l2dirty_q;
    mv_d      = mv_q;
    k_d       = k_q;
    mla_d     = mla_q;

    out_valid_d = out_valid_q && !rsp_o.ready;
    out_rd_d    = out_rd_q;
    out_cost_d  = out_cost_q;
    out_h1_d    = out_h1_q;
    out_h2_d    = out_h2_q;
    out_err_d   = out_err_q;

    l1d_we    = 1'b0;
    l1d_waddr = {idx1_q, word_q};
    l1d_wdata = wdata_q;
    l1d_raddr = {idx1_q, word_q};
    l1m_we    = 1'b0;
    l1m_waddr = idx1_q;
    l1m_wdata = {2'b10, tag1_q};
    l1m_raddr = idx1_q;
    l2d_we    = 1'b0;
    l2d_waddr = {idx2, km1};
    l2d_wdata = l1d_rdata;
    l2d_raddr = {idx2, k4};
    l2m_we    = 1'b0;
    l2m_waddr = idx2;
    l2m_wdata = {1'b1, l2wr_q | (l2hit_q & l2dirty_q), tag2};
    l2m_raddr = idx2;
    mem_we    = 1'b0;
    mem_waddr = {mla_q, km1};
    mem_wdata = l2d_rdata;
    mem_raddr = {mla_q, k4};

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        l1m_we    = 1'b1;
        l1m_waddr = clr_q[tlwc_pkg::L1_IDX_W-1:0];
        l1m_wdata = '0;
        l2m_we    = 1'b1;
        l2m_waddr = clr_q[tlwc_pkg::L2_IDX_W-1:0];
        l2m_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == MEM_WAW'(MEM_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        l1m_raddr = req_i.address[tlwc_pkg::LINE_LSB +: tlwc_pkg::L1_IDX_W];
        l1d_raddr = req_i.address[2 +: L1D_AW];
        if (req_i.valid) begin
          act_d   = req_i.action;
          idx1_d  = req_i.address[tlwc_pkg::LINE_LSB +: tlwc_pkg::L1_IDX_W];
          tag1_d  = req_i.address[tlwc_pkg::L1_TAG_LSB +: L1_TAG_W];
          word_d  = req_i.address[2 +: tlwc_pkg::WOFF_W];
          wdata_d = req_i.write_data;
          miss_d  = 1'b0;
          h1_d    = 1'b0;
          h2_d    = 1'b0;
          rd_d    = '0;
          err_d   = 1'b0;
          state_d = ST_FIN;
          case (req_i.action)
            tlwc_pkg::ACT_CLEAR: cnt_d = '0;
            tlwc_pkg::ACT_READ, tlwc_pkg::ACT_WRITE: begin
              if (|req_i.address[31:MEM_AW]) begin
                err_d = 1'b1;
              end else begin
                state_d = ST_L1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_L1: begin
        if (l1_hit_now) begin
          h1_d = !miss_q;
          if (act_q == tlwc_pkg::ACT_WRITE) begin
            l1d_we    = 1'b1;
            l1m_we    = 1'b1;
            l1m_wdata = {2'b11, tag1_q};
            cnt_d     = cnt_q + 32'(cfg_q[tlwc_pkg::CFG_L1_WR]);
          end else begin
            rd_d  = l1d_rdata;
            cnt_d = cnt_q + 32'(cfg_q[tlwc_pkg::CFG_L1_RD]);
          end
          if (out_free) begin
            out_valid_d = 1'b1;
            out_rd_d    = (act_q == tlwc_pkg::ACT_WRITE) ? 32'd0 : l1d_rdata;
            out_cost_d  = cnt_d;
            out_h1_d    = !miss_q;
            out_h2_d    = h2_q;
            out_err_d   = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          miss_d  = 1'b1;
          state_d = ST_L2M;
          if (l1m_rdata[L1M_W-1] && l1m_rdata[L1M_W-2]) begin
            phase_d = 1'b1;
            l2wr_d  = 1'b1;
            la_d    = {l1m_rdata[L1_TAG_W-1:0], idx1_q};
          end else begin
            phase_d = 1'b0;
            l2wr_d  = 1'b0;
            la_d    = {tag1_q, idx1_q};
          end
        end
      end
      ST_L2M: begin
        state_d = ST_L2C;
      end
      ST_L2C: begin
        l2hit_d   = l2_hit_now;
        l2dirty_d = l2m_rdata[L2M_W-2];
        if (!l2wr_q) begin
          h2_d = l2_hit_now;
        end
        k_d     = '0;
        state_d = ST_MOVE;
        if (l2_hit_now) begin
          mv_d = l2wr_q ? tlwc_pkg::MV_L1_TO_L2 : tlwc_pkg::MV_L2_TO_L1;
        end else if (l2m_rdata[L2M_W-1] && l2m_rdata[L2M_W-2]) begin
          mv_d  = tlwc_pkg::MV_L2_TO_MEM;
          mla_d = LA_W'({l2m_rdata[L2_TAG_W-1:0], idx2});
        end else begin
          mv_d  = tlwc_pkg::MV_MEM_TO_L2;
          mla_d = la_q;
        end
      end
      ST_MOVE: begin
        k_d = k_q + 1'b1;
        case (mv_q)
          tlwc_pkg::MV_L1_TO_L2: begin
            l1d_raddr = {idx1_q, k4};
            l2d_we    = (k_q != '0);
            l2d_wdata = l1d_rdata;
          end
          tlwc_pkg::MV_L2_TO_L1: begin
            l1d_we    = (k_q != '0);
            l1d_waddr = {idx1_q, km1};
            l1d_wdata = l2d_rdata;
          end
          tlwc_pkg::MV_L2_TO_MEM: begin
            mem_we = (k_q != '0);
          end
          tlwc_pkg::MV_MEM_TO_L2: begin
            l2d_we    = (k_q != '0);
            l2d_wdata = mem_rdata;
          end
          default: ;
        endcase
        if (k_q[K_W-1]) begin
          k_d = '0;
          case (mv_q)
            tlwc_pkg::MV_L2_TO_MEM: begin
              cnt_d = cnt_q + 32'(cfg_q[tlwc_pkg::CFG_MEM_WR]);
              mv_d  = tlwc_pkg::MV_MEM_TO_L2;
              mla_d = la_q;
            end
            tlwc_pkg::MV_MEM_TO_L2: begin
              cnt_d = cnt_q + 32'(cfg_q[tlwc_pkg::CFG_MEM_RD]);
              mv_d  = l2wr_q ? tlwc_pkg::MV_L1_TO_L2 : tlwc_pkg::MV_L2_TO_L1;
            end
            default: begin
              cnt_d  = cnt_q + 32'(l2wr_q ? cfg_q[tlwc_pkg::CFG_L2_WR] :
                                            cfg_q[tlwc_pkg::CFG_L2_RD]);
              l2m_we = 1'b1;
              if (phase_q) begin
                phase_d = 1'b0;
                l2wr_d  = 1'b0;
                la_d    = {tag1_q, idx1_q};
                state_d = ST_L2M;
              end else begin
                state_d = ST_L1UP;
              end
            end
          endcase
        end
      end
      ST_L1UP: begin
        l1m_we  = 1'b1;
        state_d = ST_L1;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rd_d    = rd_q;
          out_cost_d  = cnt_q;
          out_h1_d    = h1_q;
          out_h2_d    = h2_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      miss_q      <= 1'b0;
      phase_q     <= 1'b0;
      k_q         <= '0;
      for (int i = 0; i < tlwc_pkg::CFG_NUM; i++) begin
        cfg_q[i] <= tlwc_pkg::CFG_RESET[i];
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      miss_q      <= miss_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      if (cfg_i.valid && (cfg_i.index < tlwc_pkg::CFG_IDX_W'(tlwc_pkg::CFG_NUM))) begin
        cfg_q[cfg_i.index] <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    idx1_q     <= idx1_d;
    tag1_q     <= tag1_d;
    word_q     <= word_d;
    wdata_q    <= wdata_d;
    h1_q       <= h1_d;
    h2_q       <= h2_d;
    err_q      <= err_d;
    rd_q       <= rd_d;
    la_q       <= la_d;
    l2wr_q     <= l2wr_d;
    l2hit_q    <= l2hit_d;
    l2dirty_q  <= l2dirty_d;
    mv_q       <= mv_d;
    mla_q      <= mla_d;
    out_rd_q   <= out_rd_d;
    out_cost_q <= out_cost_d;
    out_h1_q   <= out_h1_d;
    out_h2_q   <= out_h2_d;
    out_err_q  <= out_err_d;
  end

  tlwc_ram #(.WIDTH(32), .DEPTH(tlwc_pkg::L1_LINES * tlwc_pkg::WPL)) u_l1_data (
    .clk_i, .we_i(l1d_we), .waddr_i(l1d_waddr), .wdata_i(l1d_wdata),
    .raddr_i(l1d_raddr), .rdata_o(l1d_rdata)
  );

  tlwc_ram #(.WIDTH(L1M_W), .DEPTH(tlwc_pkg::L1_LINES)) u_l1_meta (
    .clk_i, .we_i(l1m_we), .waddr_i(l1m_waddr), .wdata_i(l1m_wdata),
    .raddr_i(l1m_raddr), .rdata_o(l1m_rdata)
  );

  tlwc_ram #(.WIDTH(32), .DEPTH(tlwc_pkg::L2_LINES * tlwc_pkg::WPL)) u_l2_data (
    .clk_i, .we_i(l2d_we), .waddr_i(l2d_waddr), .wdata_i(l2d_wdata),
    .raddr_i(l2d_raddr), .rdata_o(l2d_rdata)
  );

  tlwc_ram #(.WIDTH(L2M_W), .DEPTH(tlwc_pkg::L2_LINES)) u_l2_meta (
    .clk_i, .we_i(l2m_we), .waddr_i(l2m_waddr), .wdata_i(l2m_wdata),
    .raddr_i(l2m_raddr), .rdata_o(l2m_rdata)
  );

  tlwc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_backing (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

endmodule

### rtl/tlwc_checker.sv
// port-level checks of the cache core response channel, bound to the top level
// depends on two_level_writeback_cache_core_assert.svh
`include "two_level_writeback_cache_core_assert.svh"

module tlwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_read_data_i,
  input logic [31:0] rsp_cost_i,
  input logic        rsp_l1_hit_i,
  input logic        rsp_l2_hit_i,
  input logic        rsp_err_i
);

  `TLWC_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `TLWC_ASSERT_NEXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(rsp_cost_i) && $stable(rsp_read_data_i))
  `TLWC_ASSERT_SAME(a_err_clean, rsp_valid_i && rsp_err_i, (rsp_read_data_i == 32'd0) && !rsp_l1_hit_i && !rsp_l2_hit_i)
  `TLWC_ASSERT_SAME(a_hit_excl, rsp_valid_i, !(rsp_l1_hit_i && rsp_l2_hit_i))

endmodule

bind two_level_writeback_cache_core tlwc_checker u_tlwc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_read_data_i (rsp_o.read_data),
  .rsp_cost_i      (rsp_o.elapsed_cost),
  .rsp_l1_hit_i    (rsp_o.l1_hit),
  .rsp_l2_hit_i    (rsp_o.l2_hit),
  .rsp_err_i       (rsp_o.range_error)
);
